// ===== hdl/ittd_pkg.sv =====
// Package for the integer-to-decimal-text unit.
// Holds the queued item type and the character codes.
// No dependencies.
package ittd_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CH_W       = 6;
  localparam int unsigned NUM_DIGITS = 10;

  localparam logic [CH_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CH_W-1:0] CHAR_NINE  = 6'd57;
  localparam logic [CH_W-1:0] CHAR_MINUS = 6'd45;

  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } ittd_item_t;

endpackage

// ===== hdl/int_to_decimal_text_unit.sv =====
// Integer-to-decimal-text unit: each signed 32-bit input value comes out as
// its ASCII decimal text, one character per output transfer, most significant
// digit first, preceded by '-' when negative; tlast marks the final character.
// An item gives 1 to 10 digits (the minus sign goes out from the sign state);
// the 32-step bit-serial binary-to-BCD shifter in the back end converts the
// magnitude before the first character. Inputs are taken while the back end
// works, up to the queue depth plus one held item in the front end.
// Depends on ittd_pkg, ittd_front, ittd_queue and ittd_back.
module int_to_decimal_text_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [5:0] ch, [7:6] zero
  output logic        out_tlast   // last
);
  import ittd_pkg::*;

  logic       push_valid, push_ready;
  ittd_item_t push_item;
  logic       pop_valid, pop_ready;
  ittd_item_t pop_item;
  logic [CH_W-1:0] ch;

  ittd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item)
  );

  ittd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item)
  );

  ittd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_ch    (ch),
    .out_tlast (out_tlast)
  );

  assign out_tdata = {2'b00, ch};

endmodule

// ===== hdl/ittd_front.sv =====
// Front end: accepts input values, splits them into sign and magnitude
// and holds one classified item for the queue. Uses ittd_pkg.
module ittd_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [ittd_pkg::VALUE_W-1:0] in_tdata,
  output logic                       push_valid,
  input  logic                       push_ready,
  output ittd_pkg::ittd_item_t       push_item
);
  import ittd_pkg::*;

  logic       valid_r, valid_nxt;
  ittd_item_t item_r, item_nxt;
  logic       take;

  assign in_tready  = !valid_r || push_ready;
  assign take       = in_tvalid && in_tready;
  assign push_valid = valid_r;
  assign push_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (push_ready) begin
      valid_nxt = 1'b0;
    end
    if (take) begin
      valid_nxt    = 1'b1;
      item_nxt.neg = in_tdata[VALUE_W-1];
      // unsigned negation keeps the most negative value exact
      item_nxt.mag = in_tdata[VALUE_W-1] ? (~in_tdata + 1'b1) : in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

endmodule

// ===== hdl/ittd_queue.sv =====
// Short queue between front and back end.
// Register-based FIFO of ittd_item_t entries. Uses ittd_pkg.
module ittd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  ittd_pkg::ittd_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output ittd_pkg::ittd_item_t pop_item
);
  import ittd_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  ittd_item_t         slots_r [DEPTH];
  logic [PW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign push_ready = (cnt_r != FULL_CNT);
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== hdl/ittd_back.sv =====
// Back end: bit-serial binary-to-BCD shifter over the magnitude, then
// emits sign and digits through a registered output. Uses ittd_pkg.
module ittd_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pop_valid,
  output logic                        pop_ready,
  input  ittd_pkg::ittd_item_t        pop_item,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [ittd_pkg::CH_W-1:0]   out_ch,
  output logic                        out_tlast
);
  import ittd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SIGN = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  localparam int unsigned SW = $clog2(VALUE_W);
  localparam logic [SW-1:0] LAST_SHIFT = SW'(VALUE_W - 1);

  logic [1:0]                state_r, state_nxt;
  logic [VALUE_W-1:0]        mag_r, mag_nxt;
  logic                      neg_r, neg_nxt;
  logic [NUM_DIGITS-1:0][3:0] bcd_r, bcd_nxt;
  logic [SW-1:0]             shift_r, shift_nxt;
  logic [3:0]                idx_r, idx_nxt;
  logic                      ov_r, ov_nxt;
  logic [CH_W-1:0]           ch_r, ch_nxt;
  logic                      last_r, last_nxt;

  logic                      load_ok;
  logic [NUM_DIGITS-1:0][3:0] bcd_adj;
  logic [3:0]                top_idx;

  assign load_ok    = !ov_r || out_tready;
  assign pop_ready  = (state_r == ST_IDLE);
  assign out_tvalid = ov_r;
  assign out_ch     = ch_r;
  assign out_tlast  = last_r;

  // add-3 correction per digit before each shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
  end

  // index of the most significant nonzero digit, zero for a zero value
  always_comb begin
    top_idx = '0;
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (bcd_r[i] != 4'd0) begin
        top_idx = 4'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    bcd_nxt   = bcd_r;
    shift_nxt = shift_r;
    idx_nxt   = idx_r;
    ov_nxt    = ov_r;
    ch_nxt    = ch_r;
    last_nxt  = last_r;

    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          mag_nxt   = pop_item.mag;
          neg_nxt   = pop_item.neg;
          bcd_nxt   = '0;
          shift_nxt = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_nxt   = {bcd_adj[NUM_DIGITS-1][2:0], bcd_adj[NUM_DIGITS-2:0],
                     mag_r[VALUE_W-1]};
        mag_nxt   = {mag_r[VALUE_W-2:0], 1'b0};
        shift_nxt = shift_r + 1'b1;
        if (shift_r == LAST_SHIFT) begin
          state_nxt = ST_SIGN;
        end
      end
      ST_SIGN: begin
        idx_nxt = top_idx;
        if (!neg_r) begin
          state_nxt = ST_EMIT;
        end else if (load_ok) begin
          ov_nxt    = 1'b1;
          ch_nxt    = CHAR_MINUS;
          last_nxt  = 1'b0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load_ok) begin
          ov_nxt   = 1'b1;
          ch_nxt   = CHAR_ZERO + {2'b00, bcd_r[idx_r]};
          last_nxt = (idx_r == 4'd0);
          if (idx_r == 4'd0) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    mag_r   <= mag_nxt;
    neg_r   <= neg_nxt;
    bcd_r   <= bcd_nxt;
    shift_r <= shift_nxt;
    idx_r   <= idx_nxt;
    ch_r    <= ch_nxt;
    last_r  <= last_nxt;
  end

endmodule

// ===== hdl/ittd_checker.sv =====
// Port-level checker for int_to_decimal_text_unit, bound to the top level.
// Checks output text shape over time. Uses ittd_pkg.
module ittd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast
);
  import ittd_pkg::*;

  logic start_r;
  logic after_minus_r;
  logic xfer;

  assign xfer = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r       <= 1'b1;
      after_minus_r <= 1'b0;
    end else if (xfer) begin
      start_r       <= out_tlast || (out_tdata[5:0] == CHAR_MINUS);
      after_minus_r <= (out_tdata[5:0] == CHAR_MINUS);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

  a_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:6] == 2'b00 && (out_tdata[5:0] == CHAR_MINUS ||
      (out_tdata[5:0] >= CHAR_ZERO && out_tdata[5:0] <= CHAR_NINE)))
    else $error("character out of range");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[5:0] == CHAR_MINUS |-> !out_tlast)
    else $error("minus sign marked last");

  a_digit_after_minus: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && after_minus_r |-> out_tdata[5:0] != CHAR_MINUS)
    else $error("two minus signs in a row");

  a_no_leading_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && start_r && out_tdata[5:0] == CHAR_ZERO |-> out_tlast)
    else $error("leading zero digit");

endmodule

bind int_to_decimal_text_unit ittd_checker u_ittd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast)
);
